// ----- sv/msst_pkg.sv -----
// ----------------------------------------------------------------------------
// msst_pkg
// Shared constants for the maximum subarray sum tree: default sizes and the
// fixed widths of the request and result fields.
// ----------------------------------------------------------------------------
package msst_pkg;

    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths of the ports
    localparam int POS_BITS       = 10;
    localparam int IN_VALUE_BITS  = 32;
    localparam int OUT_BITS       = 41;

endpackage

// ----- sv/max_subarray_sum_tree.sv -----
// ----------------------------------------------------------------------------
// max_subarray_sum_tree
// Maximum subarray sum over an array of signed values with point updates,
// kept in a segment tree built from one cell per tree level.
// ----------------------------------------------------------------------------
// Each request overwrites one array element and returns the largest sum of
// any contiguous run of the array afterwards (the empty run counts, so the
// result is never negative). The tree has one cell per depth, ceil(log2
// LEAVES)+1 cells, each owning a RAM with the four-value records (best run,
// best prefix, best suffix, total) of its nodes. A request walks down the
// chain one level per cycle to find its leaf, then walks back up one level
// per cycle, each cell merging the fresh child with the sibling it read from
// its own RAM. The block works on one request at a time: the next request
// can be taken in the same cycle that the result of the last one reaches
// the output register. That register has one spare slot behind it, so a
// result the consumer has not yet taken does not hold up the next request;
// only a second finished result parked behind it does, until the first one
// leaves. After reset a clearing pass zeroes every node RAM, one address a
// cycle across all levels at once, over the full address range; no request
// is taken until it ends. A position at or beyond LEAVES writes the last
// element. Value bits above VALUE_BITS are dropped.
// ----------------------------------------------------------------------------
module max_subarray_sum_tree #(
    parameter int LEAVES     = msst_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = msst_pkg::VALUE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [msst_pkg::POS_BITS-1:0]           i_position,
    input  logic signed [msst_pkg::IN_VALUE_BITS-1:0] i_new_value,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [msst_pkg::OUT_BITS-1:0]           o_best_sum
);

    localparam int D     = $clog2(LEAVES);
    localparam int NB    = VALUE_BITS + D;
    localparam int RW    = $clog2(LEAVES + 1);
    localparam int RAW_W = (msst_pkg::IN_VALUE_BITS > VALUE_BITS) ?
                           msst_pkg::IN_VALUE_BITS : VALUE_BITS;
    localparam int EW    = (NB > msst_pkg::OUT_BITS) ? NB : msst_pkg::OUT_BITS;

    typedef struct packed {
        logic signed [NB-1:0] best;
        logic signed [NB-1:0] prefix;
        logic signed [NB-1:0] suffix;
        logic signed [NB-1:0] total;
    } t_node;

    // descent request: node range and path bits from the root
    typedef struct packed {
        logic          valid;
        logic [RW-1:0] lo;
        logic [RW-1:0] hi;
        logic [D-1:0]  addr;
    } t_down;

    // ascent: updated node, its sibling and which side it sits on
    typedef struct packed {
        logic  valid;
        logic  right;
        t_node node;
        t_node sib;
    } t_up;

    // ------------------------------------------------------------------
    // Clearing pass after reset: sweep the full address range once, so every RAM address is cleared.
    // ------------------------------------------------------------------
    logic         r_clr_busy;
    logic [D-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + D'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request capture. Hold position and value for the whole walk.
    // ------------------------------------------------------------------
    logic                         in_fire;
    logic                         r_busy;
    logic                         r_start;
    logic [msst_pkg::POS_BITS-1:0] r_pos;
    logic signed [VALUE_BITS-1:0] r_value;
    logic [RAW_W-1:0]             raw_ext;
    logic signed [VALUE_BITS-1:0] in_value;

    assign o_ready  = !r_busy && !r_clr_busy;
    assign in_fire  = i_valid && o_ready;
    assign raw_ext  = RAW_W'($unsigned(i_new_value));
    assign in_value = signed'(raw_ext[VALUE_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= in_fire;
        end
        if (in_fire) begin
            r_pos   <= i_position;
            r_value <= in_value;
        end
    end

    // ------------------------------------------------------------------
    // Chain of level cells. dn[g] enters cell g from above, up[g] leaves
    // cell g toward the level above.
    // ------------------------------------------------------------------
    t_down      dn [D+2];
    t_up        up [D+2];
    logic [D:0] dn_v;
    logic [D:0] up_v;

    always_comb begin
        dn[0].valid = r_start;
        dn[0].lo    = '0;
        dn[0].hi    = RW'(LEAVES);
        dn[0].addr  = '0;
        up[D+1]     = '0;
    end

    for (genvar g = 0; g <= D; g++) begin : g_level
        msst_cell #(
            .LEAVES     (LEAVES),
            .VALUE_BITS (VALUE_BITS),
            .LEVEL      (g),
            .t_node     (t_node),
            .t_down     (t_down),
            .t_up       (t_up)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clr_en   (r_clr_busy),
            .i_clr_addr (r_clr_addr),
            .i_pos      (r_pos),
            .i_value    (r_value),
            .i_down     (dn[g]),
            .o_down     (dn[g+1]),
            .i_up       (up[g+1]),
            .o_up       (up[g])
        );

        assign dn_v[g] = dn[g].valid;
        assign up_v[g] = up[g].valid;
    end

    // ------------------------------------------------------------------
    // Result path: root best run, output register plus one spare slot.
    // ------------------------------------------------------------------
    logic                          root_valid;
    logic [EW-1:0]                 best_ext;
    logic [msst_pkg::OUT_BITS-1:0] res;
    logic                          out_free;

    logic                          r_out_valid;
    logic [msst_pkg::OUT_BITS-1:0] r_best;
    logic                          r_pend_valid;
    logic [msst_pkg::OUT_BITS-1:0] r_pend;

    logic                          n_out_valid;
    logic [msst_pkg::OUT_BITS-1:0] n_best;
    logic                          n_pend_valid;
    logic [msst_pkg::OUT_BITS-1:0] n_pend;
    logic                          n_busy;

    // the root best is never negative, so zero extension is exact
    assign root_valid = up[0].valid;
    assign best_ext   = EW'($unsigned(up[0].node.best));
    assign res        = best_ext[msst_pkg::OUT_BITS-1:0];
    assign out_free   = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_best       = r_best;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_busy       = r_busy;

        // drop the result the consumer takes this cycle
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (root_valid) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_best      = res;
                n_busy      = 1'b0;
            end else begin
                // consumer stalled: park the result
                n_pend_valid = 1'b1;
                n_pend       = res;
            end
        end else if (r_pend_valid && out_free) begin
            n_out_valid  = 1'b1;
            n_best       = r_pend;
            n_pend_valid = 1'b0;
            n_busy       = 1'b0;
        end

        if (in_fire) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_busy       <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            r_busy       <= n_busy;
        end
        r_best <= n_best;
        r_pend <= n_pend;
    end

    assign o_valid    = r_out_valid;
    assign o_best_sum = r_best;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_single_token : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dn_v, up_v}))
        else $error("more than one level active at once");

    a_root_owned : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_valid |-> r_busy)
        else $error("root result without a request in flight");

    a_pend_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_valid |-> !r_pend_valid)
        else $error("root result while the spare slot is occupied");

    a_busy_tracked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((|dn_v) || (|up_v) || r_pend_valid))
        else $error("request lost inside the tree");

    a_clear_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_busy && !(|dn_v) && !(|up_v)))
        else $error("tree activity during the clearing pass");

endmodule

// ----- sv/msst_ram.sv -----
// ----------------------------------------------------------------------------
// msst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module msst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/msst_cell.sv -----
// ----------------------------------------------------------------------------
// msst_cell
// One tree level. Holds the node records of its depth in a RAM, steers the
// descent toward the written leaf and merges the updated child with its
// sibling on the way back up.
// ----------------------------------------------------------------------------
module msst_cell #(
    parameter int  LEAVES     = msst_pkg::LEAVES_DEF,
    parameter int  VALUE_BITS = msst_pkg::VALUE_BITS_DEF,
    parameter int  LEVEL      = 0,
    parameter type t_node     = logic,
    parameter type t_down     = logic,
    parameter type t_up       = logic,
    localparam int D          = $clog2(LEAVES)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clr_en,
    input  logic [D-1:0]                      i_clr_addr,
    input  logic [msst_pkg::POS_BITS-1:0]     i_pos,
    input  logic signed [VALUE_BITS-1:0]      i_value,
    input  t_down                             i_down,
    output t_down                             o_down,
    input  t_up                               i_up,
    output t_up                               o_up
);

    localparam int NB     = VALUE_BITS + D;
    localparam int RW     = $clog2(LEAVES + 1);
    localparam int CW     = (RW > msst_pkg::POS_BITS) ? RW : msst_pkg::POS_BITS;
    localparam int AW     = (LEVEL > 0) ? LEVEL : 1;
    localparam int NODE_W = $bits(t_node);

    // descent
    logic [RW:0]   sum_lr;
    logic [RW-1:0] mid;
    logic          leaf;
    logic          go_right;
    logic [D:0]    path_ext;
    t_down         n_down;
    t_down         r_down;

    always_comb begin
        sum_lr   = {1'b0, i_down.lo} + {1'b0, i_down.hi};
        mid      = sum_lr[RW:1];
        leaf     = ((i_down.hi - i_down.lo) == RW'(1));
        go_right = !(CW'(i_pos) < CW'(mid));
        path_ext = {i_down.addr, go_right};

        n_down.valid = i_down.valid && !leaf;
        n_down.lo    = go_right ? mid : i_down.lo;
        n_down.hi    = go_right ? i_down.hi : mid;
        n_down.addr  = path_ext[D-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down.valid <= 1'b0;
        end else begin
            r_down <= n_down;
        end
    end

    assign o_down = r_down;

    // leaf record
    logic signed [NB-1:0] v_ext;
    logic signed [NB-1:0] v_clamp;
    t_node                leaf_rec;

    always_comb begin
        v_ext           = NB'(i_value);
        v_clamp         = v_ext[NB-1] ? '0 : v_ext;
        leaf_rec.best   = v_clamp;
        leaf_rec.prefix = v_clamp;
        leaf_rec.suffix = v_clamp;
        leaf_rec.total  = v_ext;
    end

    // merge of left child a and right child b
    t_node                a;
    t_node                b;
    t_node                merged;
    logic signed [NB-1:0] cross_sum;
    logic signed [NB-1:0] pre_cat;
    logic signed [NB-1:0] suf_cat;

    always_comb begin
        a         = i_up.right ? i_up.sib : i_up.node;
        b         = i_up.right ? i_up.node : i_up.sib;
        cross_sum = a.suffix + b.prefix;
        pre_cat   = a.total + b.prefix;
        suf_cat   = b.total + a.suffix;

        merged.best   = (a.best > b.best) ? a.best : b.best;
        if (cross_sum > merged.best) begin
            merged.best = cross_sum;
        end
        merged.prefix = (pre_cat > a.prefix) ? pre_cat : a.prefix;
        merged.suffix = (suf_cat > b.suffix) ? suf_cat : b.suffix;
        merged.total  = a.total + b.total;
    end

    // node storage: write own node, read its sibling in the same cycle
    logic [AW-1:0]     r_addr;
    logic              leaf_wr;
    logic [AW-1:0]     own_addr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    t_node             wr_node;
    logic [NODE_W-1:0] ram_wdata;
    logic [NODE_W-1:0] ram_rdata;

    always_comb begin
        leaf_wr   = i_down.valid && leaf;
        own_addr  = leaf_wr ? i_down.addr[AW-1:0] : r_addr;
        ram_we    = i_clr_en || leaf_wr || i_up.valid;
        ram_waddr = i_clr_en ? i_clr_addr[AW-1:0] : own_addr;
        wr_node   = leaf_wr ? leaf_rec : merged;
        ram_wdata = i_clr_en ? '0 : wr_node;
        ram_raddr = own_addr ^ AW'(1);
    end

    msst_ram #(
        .WIDTH (NODE_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // hand the updated node and its sibling to the level above
    logic  r_up_valid;
    logic  r_right;
    t_node r_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_valid <= 1'b0;
        end else begin
            r_up_valid <= leaf_wr || i_up.valid;
        end
        if (i_down.valid) begin
            r_addr <= i_down.addr[AW-1:0];
        end
        r_node  <= wr_node;
        r_right <= own_addr[0];
    end

    always_comb begin
        o_up.valid = r_up_valid;
        o_up.right = r_right;
        o_up.node  = r_node;
        o_up.sib   = t_node'(ram_rdata);
    end

endmodule

// ----- dv/max_subarray_sum_tree_test.sv -----
// ----------------------------------------------------------------------------
// max_subarray_sum_tree_test
// Point-update stimulus for the maximum subarray sum tree. A scoreboard keeps
// its own segment tree of the array, predicts the best run sum after every
// accepted request, and checks each returned result in order.
// ----------------------------------------------------------------------------
module max_subarray_sum_tree_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [msst_pkg::POS_BITS-1:0] t_pos;

    localparam logic signed [msst_pkg::IN_VALUE_BITS-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [msst_pkg::IN_VALUE_BITS-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam t_pos POS_LAST = t_pos'(msst_pkg::LEAVES_DEF - 1);

    // quiet cycles allowed: covers the clearing pass after reset, the
    // walk of one request and a long receiver stall, many times over
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 60;

    // ------------------------------------------------------------------------
    // Shadow tree of the array and the best run sums it still owes
    // ------------------------------------------------------------------------
    class max_run_tracker;
        longint run_best   [2*msst_pkg::LEAVES_DEF];
        longint run_prefix [2*msst_pkg::LEAVES_DEF];
        longint run_suffix [2*msst_pkg::LEAVES_DEF];
        longint run_total  [2*msst_pkg::LEAVES_DEF];
        logic [msst_pkg::OUT_BITS-1:0] expected_best[$];
        int errors;

        static function longint larger(longint a, longint b);
            return (a > b) ? a : b;
        endfunction

        // Overwrite one element, re-merge its path to the root, queue the root
        function void apply_write(logic [msst_pkg::POS_BITS-1:0] pos,
                                  logic signed [msst_pkg::IN_VALUE_BITS-1:0] val);
            int     n;
            int     l;
            int     r;
            longint v;
            longint clipped;
            v = longint'(val);
            clipped = larger(v, 0);
            // a position past the end lands on the last element
            n = (pos >= msst_pkg::LEAVES_DEF) ? 2*msst_pkg::LEAVES_DEF - 1
                                              : msst_pkg::LEAVES_DEF + pos;
            run_best[n]   = clipped;
            run_prefix[n] = clipped;
            run_suffix[n] = clipped;
            run_total[n]  = v;
            n = n >> 1;
            while (n >= 1) begin
                l = 2*n;
                r = 2*n + 1;
                run_best[n]   = larger(larger(run_best[l], run_best[r]),
                                       run_suffix[l] + run_prefix[r]);
                run_prefix[n] = larger(run_prefix[l], run_total[l] + run_prefix[r]);
                run_suffix[n] = larger(run_suffix[r], run_total[r] + run_suffix[l]);
                run_total[n]  = run_total[l] + run_total[r];
                n = n >> 1;
            end
            expected_best.push_back(run_best[1][msst_pkg::OUT_BITS-1:0]);
        endfunction

        function void check_best_sum(logic [msst_pkg::OUT_BITS-1:0] got);
            logic [msst_pkg::OUT_BITS-1:0] want;
            if (expected_best.size() == 0) begin
                $display("%0t: best_sum expected none, actual %0d", $time, got);
                errors++;
            end else begin
                want = expected_best.pop_front();
                if (got !== want) begin
                    $display("%0t: best_sum expected %0d, actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return expected_best.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic                                      i_clk       = 1'b0;
    logic                                      i_rst_n     = 1'b0;
    logic                                      i_valid     = 1'b0;
    logic                                      o_ready;
    logic [msst_pkg::POS_BITS-1:0]             i_position  = '0;
    logic signed [msst_pkg::IN_VALUE_BITS-1:0] i_new_value = '0;
    logic                                      o_valid;
    logic                                      i_ready     = 1'b0;
    logic [msst_pkg::OUT_BITS-1:0]             o_best_sum;

    max_run_tracker board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    max_subarray_sum_tree #(
        .LEAVES     (msst_pkg::LEAVES_DEF),
        .VALUE_BITS (msst_pkg::VALUE_BITS_DEF)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_position  (i_position),
        .i_new_value (i_new_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_best_sum  (o_best_sum)
    );

    // ------------------------------------------------------------------------
    // Observe both handshakes at the edge where they complete. Inputs change
    // only through nonblocking updates, so the values seen here are the ones
    // the block sampled at this same edge. Note the request before checking
    // so a result and a new request in one cycle stay in order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.apply_write(i_position, i_new_value);
            end
            if (o_valid && i_ready) begin
                board.check_best_sum(o_best_sum);
            end
        end
    end

    // Receiver: drop ready at random, at the rate of the current phase
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: give up after a long stretch with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each is entered at a rising edge. Valid is lowered only
    // when a gap is taken, so it never falls and rises in one time step, and
    // it holds with a fixed payload until the block takes the request.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [msst_pkg::POS_BITS-1:0] pos,
                                input logic signed [msst_pkg::IN_VALUE_BITS-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_position  <= pos;
        i_new_value <= val;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold off new requests until every owed result has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random requests: half of them land in a narrow window that moves now
    // and then, so runs of neighbors form and merge across subtrees; values
    // mix extremes, small signed numbers and full-width noise.
    task automatic run_phase(input int count, input int send_pct, input int recv_pct);
        logic [msst_pkg::POS_BITS-1:0]             window_base;
        logic [msst_pkg::POS_BITS-1:0]             pos;
        logic signed [msst_pkg::IN_VALUE_BITS-1:0] val;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        window_base = t_pos'($urandom);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                window_base = t_pos'($urandom);
            end
            if ($urandom_range(1) == 1) begin
                pos = t_pos'(window_base + $urandom_range(31));
            end else begin
                pos = t_pos'($urandom);
            end
            case ($urandom_range(9)) inside
                0:       val = VALUE_MAX;
                1:       val = VALUE_MIN;
                [2:4]:   val = $urandom_range(400) - 200;
                [5:7]:   val = $urandom;
                8:       val = $urandom_range(32'h7FFF_FFFF);
                default: val = '0;
            endcase
            send_request(pos, val);
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // hold reset, then release it; the clearing pass follows on its own
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 86;

        // Directed: both ends of the array, the two halves meeting in the
        // middle, the largest and smallest values, alternating bit patterns.
        // Ten position bits cannot exceed the last element, and the value
        // port is exactly as wide as the stored value, so nothing is dropped.
        send_request('0, VALUE_MAX);
        send_request(POS_LAST, VALUE_MAX);
        send_request(10'd511, VALUE_MAX);
        send_request(10'd512, VALUE_MAX);
        send_request(10'd1, VALUE_MIN);
        send_request(10'd1022, VALUE_MIN);
        send_request(10'd256, -32'sd1);
        send_request(10'd768, 32'sd1);
        send_request(10'h155, 32'sh5555_5555);
        send_request(10'h2AA, 32'shAAAA_AAAA);
        send_request('0, '0);
        send_request(POS_LAST, VALUE_MIN);
        send_request(10'd512, VALUE_MIN);
        send_request(10'd511, '0);
        send_request(10'd1, 32'sd1);
        send_request(POS_LAST, -32'sd1);
        send_request('0, VALUE_MIN);
        send_request(10'd513, VALUE_MAX);

        // drain fully once before the random part
        wait_for_results();

        run_phase(310, 13, 86);
        run_phase(310, 86, 13);
        run_phase(310, 0, 0);

        // catch anything the block sends after the last owed result
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/msst_pkg.sv
sv/msst_ram.sv
sv/msst_cell.sv
sv/max_subarray_sum_tree.sv
dv/max_subarray_sum_tree_test.sv
